// File: design/assert_macros.svh
// Assertion helpers for the design checker in chgw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define CHGW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHGW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/chgw_pkg.sv
package chgw_pkg;

    // Width of the coordinate ports.
    localparam int FIELD_W = 16;

    // Defaults for the top-level parameters.
    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_OPEN = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_LOAD,
        S_MIN_RD,
        S_MIN_CMP,
        S_VTX,
        S_QLD,
        S_SC_RD,
        S_SC_MUL,
        S_SC_CMP,
        S_STEP,
        S_EMIT_RD,
        S_EMIT_WR,
        S_ERR
    } t_state;

endpackage

// File: design/chgw_ram.sv
module chgw_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data is registered and holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/chgw_orient.sv
module chgw_orient #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [COORD_WIDTH-1:0] i_px,
    input  logic [COORD_WIDTH-1:0] i_py,
    input  logic [COORD_WIDTH-1:0] i_bx,
    input  logic [COORD_WIDTH-1:0] i_by,
    input  logic [COORD_WIDTH-1:0] i_qx,
    input  logic [COORD_WIDTH-1:0] i_qy,
    output logic                   o_ccw
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] w_d1, w_d2, w_d3, w_d4;
    logic signed [PW-1:0] r_prod1, r_prod2;

    // Orientation of (p, b, q): (By-Py)*(Qx-Bx) - (Bx-Px)*(Qy-By), negative
    // means counter-clockwise. Both products are kept exact.
    assign w_d1 = DW'($signed(i_by)) - DW'($signed(i_py));
    assign w_d2 = DW'($signed(i_qx)) - DW'($signed(i_bx));
    assign w_d3 = DW'($signed(i_bx)) - DW'($signed(i_px));
    assign w_d4 = DW'($signed(i_qy)) - DW'($signed(i_by));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1 <= PW'(w_d1) * PW'(w_d2);
            r_prod2 <= PW'(w_d3) * PW'(w_d4);
        end
    end

    assign o_ccw = (r_prod1 < r_prod2);

endmodule

// File: design/convex_hull_gift_wrap.sv
// Convex hull by gift wrapping over a set of signed 2-D points.
// Input channel (i_in_valid / o_in_ready): one point per transaction; a
// transaction with i_last_point high closes the set and starts the hull.
// While loading, up to MAX_POINTS points are kept and o_in_ready stays high;
// further points are dropped, though their last flag still counts.
// Output channel (o_out_valid / i_out_ready): one transaction per hull
// vertex in counter-clockwise walk order starting at the leftmost point,
// the final one with o_hull_last high. Fewer than three points give one
// error transaction with status 1, and a walk that does not close within
// the point count gives one with status 2; both carry zero coordinates.
// After the last point the block reads every point to find the leftmost,
// then per hull vertex records it, loads the first candidate and scans
// all points (read, multiply, compare), then streams the vertices out.
// The scan is bound by the point memory's single read port and by the
// orientation unit, whose result sets the candidate before the next compare.
// The block takes no new points while a set is being processed; it takes
// them again as soon as the final result sits in the output register.
// A stalled receiver holds the current result in place and pauses the
// stream. Reset empties the point set and the output register; memory
// contents are not cleared, since only entries of the current set are read.
module convex_hull_gift_wrap #(
    parameter int MAX_POINTS  = chgw_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = chgw_pkg::COORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [chgw_pkg::FIELD_W-1:0] i_point_x,
    input  logic [chgw_pkg::FIELD_W-1:0] i_point_y,
    input  logic                         i_last_point,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [chgw_pkg::FIELD_W-1:0] o_hull_x,
    output logic [chgw_pkg::FIELD_W-1:0] o_hull_y,
    output logic                         o_hull_last,
    output logic [1:0]                   o_status
);

    localparam int CW     = COORD_WIDTH;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int EXT_W  = 48;

    chgw_pkg::t_state r_state, n_state;

    // Control registers.
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;

    // Walk registers.
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_k;
    logic [ADDR_W-1:0] r_i, r_p, r_q, r_start, r_j;
    logic [CW-1:0]     r_px, r_py, r_qx, r_qy;
    chgw_pkg::t_status r_err;

    // Output register payload.
    logic [chgw_pkg::FIELD_W-1:0] r_hull_x, r_hull_y;
    logic                         r_hull_last;
    chgw_pkg::t_status            r_status;

    // Memory controls.
    logic              w_pt_we, w_pt_re;
    logic [ADDR_W-1:0] w_pt_raddr;
    logic [2*CW-1:0]   w_pt_rd;
    logic              w_hl_we, w_hl_re;
    logic [2*CW-1:0]   w_hl_rd;

    logic              w_in_acc, w_slot, w_ccw, w_orient_en;
    logic              w_i_last, w_j_last, w_few;
    logic [CNT_W-1:0]  w_cnt_next;
    logic [ADDR_W-1:0] w_q_next;
    logic [CW-1:0]     w_rd_x, w_rd_y;
    logic [EXT_W-1:0]  w_in_x_ext, w_in_y_ext, w_out_x_ext, w_out_y_ext;

    // Coordinates use the low COORD_WIDTH bits of each field.
    assign w_in_x_ext = EXT_W'(i_point_x);
    assign w_in_y_ext = EXT_W'(i_point_y);
    assign w_rd_x     = w_pt_rd[2*CW-1:CW];
    assign w_rd_y     = w_pt_rd[CW-1:0];
    assign w_out_x_ext = EXT_W'(w_hl_rd[2*CW-1:CW]);
    assign w_out_y_ext = EXT_W'(w_hl_rd[CW-1:0]);

    assign o_in_ready = (r_state == chgw_pkg::S_LOAD);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_slot     = !r_out_valid || i_out_ready;

    // A point beyond the store capacity is not written and not counted.
    assign w_cnt_next = (r_cnt < CNT_W'(MAX_POINTS)) ? r_cnt + CNT_W'(1) : r_cnt;
    assign w_few      = (w_cnt_next < CNT_W'(3));
    assign w_i_last   = (CNT_W'(r_i) == r_n - CNT_W'(1));
    assign w_j_last   = (CNT_W'(r_j) + CNT_W'(1) == r_k);
    assign w_q_next   = (CNT_W'(r_p) + CNT_W'(1) == r_n) ? '0 : r_p + ADDR_W'(1);

    // The point memory is written only while loading and the hull memory
    // is read only while streaming, so no access pair overlaps.
    chgw_ram #(
        .WIDTH  (2 * CW),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata ({w_in_x_ext[CW-1:0], w_in_y_ext[CW-1:0]}),
        .i_re    (w_pt_re),
        .i_raddr (w_pt_raddr),
        .o_rdata (w_pt_rd)
    );

    chgw_ram #(
        .WIDTH  (2 * CW),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W)
    ) u_hull_ram (
        .i_clk   (i_clk),
        .i_we    (w_hl_we),
        .i_waddr (r_k[ADDR_W-1:0]),
        .i_wdata ({r_px, r_py}),
        .i_re    (w_hl_re),
        .i_raddr (r_j),
        .o_rdata (w_hl_rd)
    );

    chgw_orient #(
        .COORD_WIDTH (CW)
    ) u_orient (
        .i_clk (i_clk),
        .i_en  (w_orient_en),
        .i_px  (r_px),
        .i_py  (r_py),
        .i_bx  (w_rd_x),
        .i_by  (w_rd_y),
        .i_qx  (r_qx),
        .i_qy  (r_qy),
        .o_ccw (w_ccw)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            chgw_pkg::S_LOAD: begin
                if (w_in_acc && i_last_point) begin
                    n_state = w_few ? chgw_pkg::S_ERR : chgw_pkg::S_MIN_RD;
                end
            end
            chgw_pkg::S_MIN_RD:  n_state = chgw_pkg::S_MIN_CMP;
            chgw_pkg::S_MIN_CMP: n_state = w_i_last ? chgw_pkg::S_VTX : chgw_pkg::S_MIN_RD;
            chgw_pkg::S_VTX:     n_state = chgw_pkg::S_QLD;
            chgw_pkg::S_QLD:     n_state = chgw_pkg::S_SC_RD;
            chgw_pkg::S_SC_RD:   n_state = chgw_pkg::S_SC_MUL;
            chgw_pkg::S_SC_MUL:  n_state = chgw_pkg::S_SC_CMP;
            chgw_pkg::S_SC_CMP:  n_state = w_i_last ? chgw_pkg::S_STEP : chgw_pkg::S_SC_RD;
            chgw_pkg::S_STEP: begin
                if (r_q == r_start) begin
                    n_state = chgw_pkg::S_EMIT_RD;
                end else if (r_k == r_n) begin
                    n_state = chgw_pkg::S_ERR;
                end else begin
                    n_state = chgw_pkg::S_VTX;
                end
            end
            chgw_pkg::S_EMIT_RD: n_state = chgw_pkg::S_EMIT_WR;
            chgw_pkg::S_EMIT_WR: begin
                if (w_slot) begin
                    n_state = w_j_last ? chgw_pkg::S_LOAD : chgw_pkg::S_EMIT_RD;
                end
            end
            chgw_pkg::S_ERR: begin
                if (w_slot) begin
                    n_state = chgw_pkg::S_LOAD;
                end
            end
            default: n_state = chgw_pkg::S_LOAD;
        endcase
    end

    // Memory and orientation unit controls.
    always_comb begin
        w_pt_we     = 1'b0;
        w_pt_re     = 1'b0;
        w_pt_raddr  = r_i;
        w_hl_we     = 1'b0;
        w_hl_re     = 1'b0;
        w_orient_en = 1'b0;
        case (r_state)
            chgw_pkg::S_LOAD:    w_pt_we = w_in_acc && (r_cnt < CNT_W'(MAX_POINTS));
            chgw_pkg::S_MIN_RD:  w_pt_re = 1'b1;
            chgw_pkg::S_VTX: begin
                w_hl_we    = 1'b1;
                w_pt_re    = 1'b1;
                w_pt_raddr = w_q_next;
            end
            chgw_pkg::S_SC_RD:   w_pt_re = 1'b1;
            chgw_pkg::S_SC_MUL:  w_orient_en = 1'b1;
            chgw_pkg::S_EMIT_RD: w_hl_re = 1'b1;
            default: begin
                w_pt_we = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chgw_pkg::S_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_cnt <= i_last_point ? '0 : w_cnt_next;
            end
            if (((r_state == chgw_pkg::S_EMIT_WR) || (r_state == chgw_pkg::S_ERR))
                && w_slot) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk datapath and output payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            chgw_pkg::S_LOAD: begin
                if (w_in_acc && i_last_point) begin
                    r_n   <= w_cnt_next;
                    r_i   <= '0;
                    r_err <= chgw_pkg::ST_FEW;
                end
            end
            chgw_pkg::S_MIN_CMP: begin
                // The first point with the smallest x wins a tie.
                if ((r_i == '0) || ($signed(w_rd_x) < $signed(r_px))) begin
                    r_start <= r_i;
                    r_p     <= r_i;
                    r_px    <= w_rd_x;
                    r_py    <= w_rd_y;
                end
                r_i <= w_i_last ? '0 : r_i + ADDR_W'(1);
                r_k <= '0;
            end
            chgw_pkg::S_VTX: begin
                r_q <= w_q_next;
                r_k <= r_k + CNT_W'(1);
            end
            chgw_pkg::S_QLD: begin
                r_qx <= w_rd_x;
                r_qy <= w_rd_y;
                r_i  <= '0;
            end
            chgw_pkg::S_SC_CMP: begin
                if (w_ccw) begin
                    r_q  <= r_i;
                    r_qx <= w_rd_x;
                    r_qy <= w_rd_y;
                end
                r_i <= w_i_last ? '0 : r_i + ADDR_W'(1);
            end
            chgw_pkg::S_STEP: begin
                r_p   <= r_q;
                r_px  <= r_qx;
                r_py  <= r_qy;
                r_j   <= '0;
                r_err <= chgw_pkg::ST_OPEN;
            end
            chgw_pkg::S_EMIT_WR: begin
                if (w_slot) begin
                    r_hull_x    <= w_out_x_ext[chgw_pkg::FIELD_W-1:0];
                    r_hull_y    <= w_out_y_ext[chgw_pkg::FIELD_W-1:0];
                    r_hull_last <= w_j_last;
                    r_status    <= chgw_pkg::ST_OK;
                    r_j         <= r_j + ADDR_W'(1);
                end
            end
            chgw_pkg::S_ERR: begin
                if (w_slot) begin
                    r_hull_x    <= '0;
                    r_hull_y    <= '0;
                    r_hull_last <= 1'b1;
                    r_status    <= r_err;
                end
            end
            default: begin
                r_j <= r_j;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_hull_x    = r_hull_x;
    assign o_hull_y    = r_hull_y;
    assign o_hull_last = r_hull_last;
    assign o_status    = r_status;

endmodule

// File: design/chgw_checker.sv
`include "assert_macros.svh"

module chgw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [chgw_pkg::FIELD_W-1:0] i_point_x,
    input logic [chgw_pkg::FIELD_W-1:0] i_point_y,
    input logic                         i_last_point,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [chgw_pkg::FIELD_W-1:0] o_hull_x,
    input logic [chgw_pkg::FIELD_W-1:0] o_hull_y,
    input logic                         o_hull_last,
    input logic [1:0]                   o_status
);

    // A stalled result keeps its payload.
    `CHGW_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hull_x) && $stable(o_hull_y) && $stable(o_hull_last) && $stable(o_status), "stalled result changed")

    // Error results are marked final and carry zero coordinates.
    `CHGW_ASSERT(a_err_form, i_clk, i_rst_n, o_out_valid && (o_status != chgw_pkg::ST_OK) |-> o_hull_last && (o_hull_x == '0) && (o_hull_y == '0), "malformed error result")

    // Loading stops only after a transaction that closes the set.
    `CHGW_ASSERT(a_ready_fall, i_clk, i_rst_n, $fell(o_in_ready) |-> $past(i_in_valid && i_last_point), "input stalled without a closing point")

    // After reset the block is empty and ready to load.
    `CHGW_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready, "bad state after reset")

endmodule

bind convex_hull_gift_wrap chgw_checker u_chgw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_point_x    (i_point_x),
    .i_point_y    (i_point_y),
    .i_last_point (i_last_point),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_hull_x     (o_hull_x),
    .o_hull_y     (o_hull_y),
    .o_hull_last  (o_hull_last),
    .o_status     (o_status)
);

// File: dv/convex_hull_gift_wrap_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the hull block. It keeps its own point store,
// works out the hull of every finished set, and compares each result
// transaction with the oldest vertex still due.
module convex_hull_gift_wrap_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [chgw_pkg::FIELD_W-1:0] i_point_x,
    input  logic [chgw_pkg::FIELD_W-1:0] i_point_y,
    input  logic                         i_last_point,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [chgw_pkg::FIELD_W-1:0] i_hull_x,
    input  logic [chgw_pkg::FIELD_W-1:0] i_hull_y,
    input  logic                         i_hull_last,
    input  logic [1:0]                   i_status,
    output int                           o_err_count,
    output int                           o_pending,
    output int                           o_sets,
    output int                           o_results,
    output int                           o_few,
    output int                           o_open,
    output int                           o_dropped
);
    import chgw_pkg::*;

    localparam int MAX_PTS = MAX_POINTS_DEF;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic                      last;
        t_status                   status;
    } hull_vtx_t;

    logic signed [FIELD_W-1:0] pt_x [MAX_PTS];
    logic signed [FIELD_W-1:0] pt_y [MAX_PTS];
    int                        pt_count;
    hull_vtx_t                 hull_due [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_sets      = 0;
        o_results   = 0;
        o_few       = 0;
        o_open      = 0;
        o_dropped   = 0;
        pt_count    = 0;
    end

    // True when a -> b -> c turns counter-clockwise; the cross product is
    // at most 35 bits wide, so 64-bit arithmetic keeps it exact.
    function automatic bit turns_left(int a, int b, int c);
        longint abx, aby, bcx, bcy;
        abx = longint'(pt_x[b]) - longint'(pt_x[a]);
        aby = longint'(pt_y[b]) - longint'(pt_y[a]);
        bcx = longint'(pt_x[c]) - longint'(pt_x[b]);
        bcy = longint'(pt_y[c]) - longint'(pt_y[b]);
        return (aby * bcx - abx * bcy) < 0;
    endfunction

    function automatic void push_vertex(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                        logic last, t_status status);
        hull_due.push_back(hull_vtx_t'{x: x, y: y, last: last, status: status});
    endfunction

    // Gift-wrapping walk over the stored set; the store is emptied after.
    function automatic void wrap_hull();
        int n;
        int start;
        int p;
        int q;
        int k;
        bit closed;
        int walk [MAX_PTS];
        n        = pt_count;
        pt_count = 0;
        closed   = 1'b0;
        if (n < 3) begin
            push_vertex('0, '0, 1'b1, ST_FEW);
            o_few++;
            return;
        end
        start = 0;
        for (int i = 1; i < n; i++) begin
            if (pt_x[i] < pt_x[start]) begin
                start = i;
            end
        end
        p = start;
        k = 0;
        while (k < n && !closed) begin
            walk[k] = p;
            k++;
            q = (p + 1) % n;
            for (int i = 0; i < n; i++) begin
                if (turns_left(p, i, q)) begin
                    q = i;
                end
            end
            p = q;
            closed = (p == start);
        end
        if (!closed) begin
            push_vertex('0, '0, 1'b1, ST_OPEN);
            o_open++;
            return;
        end
        for (int i = 0; i < k; i++) begin
            push_vertex(pt_x[walk[i]], pt_y[walk[i]], i == k - 1, ST_OK);
        end
    endfunction

    function automatic void take_point(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                       logic last);
        if (pt_count < MAX_PTS) begin
            pt_x[pt_count] = x;
            pt_y[pt_count] = y;
            pt_count++;
        end else begin
            o_dropped++;
        end
        if (last) begin
            o_sets++;
            wrap_hull();
        end
    endfunction

    function automatic void compare_field(string name, logic [FIELD_W-1:0] want,
                                          logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
            o_err_count++;
        end
    endfunction

    function automatic void check_vertex();
        hull_vtx_t want;
        o_results++;
        if (hull_due.size() == 0) begin
            $error("unexpected result: hull_x %0d hull_y %0d hull_last %0b status %0d",
                   $signed(i_hull_x), $signed(i_hull_y), i_hull_last, i_status);
            o_err_count++;
            return;
        end
        want = hull_due.pop_front();
        compare_field("hull_x", want.x, i_hull_x);
        compare_field("hull_y", want.y, i_hull_y);
        compare_field("hull_last", {{(FIELD_W-1){1'b0}}, want.last},
                      {{(FIELD_W-1){1'b0}}, i_hull_last});
        compare_field("status", {{(FIELD_W-2){1'b0}}, want.status},
                      {{(FIELD_W-2){1'b0}}, i_status});
    endfunction

    // Both channels are sampled at the edge, before the block's outputs and
    // the stimulus update, so every transaction is seen with its own payload.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_count = 0;
            hull_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_vertex();
            end
            if (i_in_valid && i_in_ready) begin
                take_point(i_point_x, i_point_y, i_last_point);
            end
        end
        o_pending = hull_due.size();
    end

endmodule

// File: dv/convex_hull_gift_wrap_tb.sv
`timescale 1ns / 100ps

// Top of the hull block testbench. It makes the clock, the reset and the
// point stimulus, drives the receiver's ready, and keeps a watchdog. All
// prediction and comparison happens in the checker instantiated beside the
// block; this module only turns its failure count into the verdict.
module convex_hull_gift_wrap_tb;
    import chgw_pkg::*;

    // The slowest quiet stretch is a full 64-vertex walk over 64 points.
    // The limit leaves ample room on top of that for the long receiver
    // hold-off and random stalls.
    localparam int WATCHDOG_LIMIT = 60000;
    // Length of the deliberate receiver hold-off, long enough that the block
    // finishes a walk and backs up into its input channel.
    localparam int HOLD_CYCLES    = 2500;
    // Cycles to watch for stray results after the last expected one.
    localparam int TAIL_CYCLES    = 500;
    localparam int PHASE_ITEMS    = 60;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic [FIELD_W-1:0] i_point_x    = '0;
    logic [FIELD_W-1:0] i_point_y    = '0;
    logic               i_last_point = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic [FIELD_W-1:0] o_hull_x;
    logic [FIELD_W-1:0] o_hull_y;
    logic               o_hull_last;
    logic [1:0]         o_status;

    int chk_errors;
    int chk_pending;
    int chk_sets;
    int chk_results;
    int chk_few;
    int chk_open;
    int chk_dropped;

    idle_mode_t         idle_mode    = IDLE_NONE;
    int                 n_items      = 0;
    int                 quiet_cycles = 0;
    // The main process asks for a hold-off by bumping hold_asked; the receiver
    // process runs it and bumps hold_served, so each counter has one writer.
    int                 hold_asked   = 0;
    int                 hold_served  = 0;
    // Points of the set that is about to be sent, in order.
    logic [FIELD_W-1:0] set_x [$];
    logic [FIELD_W-1:0] set_y [$];
    int                 corners [6] = '{-32768, 32767, -32767, 32766, 0, -1};

    convex_hull_gift_wrap u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hull_x     (o_hull_x),
        .o_hull_y     (o_hull_y),
        .o_hull_last  (o_hull_last),
        .o_status     (o_status)
    );

    convex_hull_gift_wrap_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_hull_x     (o_hull_x),
        .i_hull_y     (o_hull_y),
        .i_hull_last  (o_hull_last),
        .i_status     (o_status),
        .o_err_count  (chk_errors),
        .o_pending    (chk_pending),
        .o_sets       (chk_sets),
        .o_results    (chk_results),
        .o_few        (chk_few),
        .o_open       (chk_open),
        .o_dropped    (chk_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit coin(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SEND: return coin(81);
            IDLE_BOTH: return coin(12);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return coin(81);
            IDLE_BOTH: return coin(12);
            default:   return 1'b0;
        endcase
    endfunction

    // Receiver side. Ready is redrawn every cycle from the current idle mode,
    // except during a requested hold-off, which this process times from
    // HOLD_CYCLES; ready stays low then while the sender keeps offering points.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_asked) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_served++;
            end else begin
                i_out_ready <= !receiver_stalls();
            end
        end
    end

    // Watchdog: any cycle without a transaction on either channel counts.
    // A hung block, or an expected result that never comes, ends up here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one point and returns at the edge where it is taken. Valid is
    // left high afterwards so that back-to-back points follow without a gap;
    // it goes low only when the next call idles or a drain starts.
    task automatic send_point(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic last);
        while (sender_idles()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
    endtask

    task automatic add_point(int x, int y);
        set_x.push_back(x[FIELD_W-1:0]);
        set_y.push_back(y[FIELD_W-1:0]);
    endtask

    // Sends the queued set, flagging its final point, and empties the queue.
    task automatic play_set();
        for (int i = 0; i < set_x.size(); i++) begin
            send_point(set_x[i], set_y[i], i == set_x.size() - 1);
        end
        set_x.delete();
        set_y.delete();
    endtask

    // Sender pause: nothing is offered until every result the checker still
    // waits for has come. The first edge lets the checker take in the final
    // point of the set before its count of pending results is looked at.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (chk_pending == 0);
        @(posedge i_clk);
    endtask

    // Coordinates come in four flavors: the full 16-bit range, a tiny range
    // that produces duplicates and collinear points, a middle range, and the
    // extreme values that stress the width of the cross product.
    function automatic int rand_coord(int style);
        case (style)
            0:       return int'($urandom_range(65535)) - 32768;
            1:       return int'($urandom_range(12)) - 6;
            2:       return int'($urandom_range(400)) - 200;
            default: return corners[$urandom_range(5)];
        endcase
    endfunction

    // Mostly ordinary sets of three to a dozen points; a few sets too small
    // for a hull, a few larger ones, and now and then a repeated point, which
    // is what can keep the walk from closing.
    task automatic make_random_set();
        int r;
        int n;
        int style;
        int pick;
        r     = $urandom_range(99);
        n     = (r < 6) ? $urandom_range(2, 1) :
                (r < 90) ? $urandom_range(12, 3) : $urandom_range(24, 13);
        style = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            add_point(rand_coord(style), rand_coord(style));
        end
        if (n >= 3 && coin(15)) begin
            pick = $urandom_range(n - 1);
            set_x.push_back(set_x[pick]);
            set_y.push_back(set_y[pick]);
        end
    endtask

    task automatic run_phase(idle_mode_t mode);
        int first;
        idle_mode = mode;
        first     = n_items;
        while (n_items - first < PHASE_ITEMS) begin
            make_random_set();
            play_set();
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets, sent back to back with no idling.
        // A lone point and a pair are both too few for a hull.
        add_point(0, 0);
        play_set();
        add_point(32767, -32768);
        add_point(-32768, 32767);
        play_set();
        // A triangle spanning the full coordinate range.
        add_point(-32768, -32768);
        add_point(32767, -32768);
        add_point(0, 32767);
        play_set();
        // The leftmost point repeated, with one more point after the copy:
        // the walk ends on the copy instead of the start, goes round again
        // and runs out of vertices, an open walk.
        add_point(0, 0);
        add_point(5, -5);
        add_point(5, 5);
        add_point(0, 0);
        add_point(1, 0);
        play_set();
        // Three collinear points.
        add_point(1, 1);
        add_point(2, 2);
        add_point(3, 3);
        play_set();
        // Corners of the full square, two sharing the smallest x, with an
        // interior point that must not show up on the hull.
        add_point(-32768, 32767);
        add_point(-32768, -32768);
        add_point(32767, -32768);
        add_point(32767, 32767);
        add_point(0, 0);
        play_set();
        // A vertical line: every point has the same x.
        add_point(7, 1);
        add_point(7, -3);
        add_point(7, 9);
        play_set();
        drain();

        // Long receiver hold-off while three sets are offered back to back:
        // the first result parks in the output register and the block stops
        // taking points until the hold ends.
        hold_asked++;
        repeat (3) begin
            make_random_set();
            play_set();
        end
        drain();

        // Full store: 64 points on a parabola, all of them hull vertices,
        // then six more that are dropped. The last flag rides on a dropped
        // point and still starts the walk.
        for (int v = -32; v < 32; v++) begin
            add_point(v, v * v);
        end
        repeat (6) add_point(rand_coord(0), rand_coord(0));
        play_set();
        drain();

        // Random sets under each idling pattern.
        run_phase(IDLE_NONE);
        run_phase(IDLE_SEND);
        run_phase(IDLE_RECV);
        run_phase(IDLE_BOTH);

        // Everything expected has arrived; keep watching for stray results.
        idle_mode = IDLE_NONE;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d points in %0d sets; %0d results compared.",
                 n_items, chk_sets, chk_results);
        $display("Error results seen: %0d too-few sets, %0d open walks; %0d points dropped.",
                 chk_few, chk_open, chk_dropped);
        if (chk_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
